[rtl/core/cidat_pkg.sv]
`timescale 1ns / 1ps
// Package for the card ID access table: field widths, command codes and status codes.
// It depends on nothing. The interfaces and the top level use it.
package cidat_pkg;

  localparam int CMD_W    = 2;
  localparam int ID_W     = 32;
  localparam int STATUS_W = 4;
  localparam int SLOT_W   = 5;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [ID_W-1:0]     card_id_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [SLOT_W-1:0]   slot_t;

  localparam cmd_t CMD_PRESENT = 2'd0;
  localparam cmd_t CMD_ADD     = 2'd1;
  localparam cmd_t CMD_DELETE  = 2'd2;
  localparam cmd_t CMD_CLEAR   = 2'd3;

  localparam status_t ST_ENROLLED = 4'd0;
  localparam status_t ST_MASTER   = 4'd1;
  localparam status_t ST_GRANTED  = 4'd2;
  localparam status_t ST_DENIED   = 4'd3;
  localparam status_t ST_ALREADY  = 4'd4;
  localparam status_t ST_ADDED    = 4'd5;
  localparam status_t ST_FULL     = 4'd6;
  localparam status_t ST_DELETED  = 4'd7;
  localparam status_t ST_NOTFOUND = 4'd8;
  localparam status_t ST_EMPTY    = 4'd9;
  localparam status_t ST_CLEARED  = 4'd10;

endpackage

[rtl/core/cidat_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the card ID access table.
// They depend on cidat_pkg for the field types.
interface cidat_in_if;
  logic                valid;
  logic                ready;
  cidat_pkg::cmd_t     cmd;
  cidat_pkg::card_id_t card_id;

  modport source (output valid, output cmd, output card_id, input ready);
  modport sink   (input valid, input cmd, input card_id, output ready);
endinterface

interface cidat_out_if;
  logic               valid;
  logic               ready;
  cidat_pkg::status_t status;
  cidat_pkg::slot_t   slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink   (input valid, input status, input slot, output ready);
endinterface

[rtl/core/card_id_access_table_unit.sv]
`timescale 1ns / 1ps
// Top level of the card ID access table: master card, ID table walk and result register.
// It depends on cidat_pkg, the channel interfaces in cidat_if and the RAM cidat_ram.
//
//   Channel   Direction  Handshake            Payload
//   in_ch     sink       valid / ready        cmd (2 bits), card_id (32 bits)
//   out_ch    source     valid / ready        status (4 bits), slot (5 bits)
//
// An item that needs no table walk (enrolment, a master match, an empty table, clear)
// is settled in the check state. One that walks the table steps the single read port of
// the ID RAM through the entries, one per cycle, and the walk stops at a match.
// Reset clears the valid marks at once, so there is no clearing pass; the IDs in the RAM
// need no reset because a slot is only compared while its valid mark is set.
// The block takes one item at a time. A finished result waits in the output register
// while the next item is accepted and worked on; that item stalls only at its end.
module card_id_access_table_unit #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  cidat_in_if.sink    in_ch,
  cidat_out_if.source out_ch
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for an item
  localparam logic [1:0] S_CHECK = 2'd1;  // decisions that need no table walk
  localparam logic [1:0] S_SCAN  = 2'd2;  // walk over the ID RAM
  localparam logic [1:0] S_FIN   = 2'd3;  // hand the result to the output register

  logic [1:0] state_r, state_nxt;

  // The item being worked on.
  cidat_pkg::cmd_t     cmd_r;
  cidat_pkg::card_id_t id_r;

  // Master card and the valid marks of the table.
  cidat_pkg::card_id_t      master_id_r, master_id_nxt;
  logic                     master_valid_r, master_valid_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;

  // Walk control: addr_r is the slot being read, chk_idx_r the slot whose data is out.
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic             chk_r, chk_nxt;
  logic             free_found_r, free_found_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;

  // Result waiting for the finish state, and the output register.
  cidat_pkg::status_t res_status_r, res_status_nxt;
  cidat_pkg::slot_t   res_slot_r, res_slot_nxt;
  logic               out_valid_r, out_valid_nxt;
  cidat_pkg::status_t out_status_r;
  cidat_pkg::slot_t   out_slot_r;

  // RAM ports.
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic                ram_re;
  cidat_pkg::card_id_t ram_rdata;

  logic             accept;
  logic             load_out;
  logic             tbl_empty;
  logic             master_hit;
  logic             entry_hit;
  logic             scan_end;
  logic             free_any;
  logic [IDX_W-1:0] free_sel;

  cidat_ram #(
    .WIDTH (cidat_pkg::ID_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_id_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (id_r),
    .rd_en   (ram_re),
    .rd_addr (addr_r),
    .rd_data (ram_rdata)
  );

  assign in_ch.ready   = (state_r == S_IDLE);
  assign accept        = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.slot   = out_slot_r;

  assign load_out   = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);
  assign tbl_empty  = ~|valid_r;
  assign master_hit = master_valid_r && (master_id_r == id_r);
  assign ram_re     = (state_r == S_SCAN);

  // The slot whose data has just come out of the RAM is compared only while it is valid.
  assign entry_hit = chk_r && valid_r[chk_idx_r] && (ram_rdata == id_r);
  assign scan_end  = chk_r && (entry_hit || (chk_idx_r == LAST_IDX));

  // Lowest free slot seen so far, including the one being looked at now.
  assign free_any = free_found_r || !valid_r[chk_idx_r];
  assign free_sel = free_found_r ? free_idx_r : chk_idx_r;

  always_comb begin
    state_nxt        = state_r;
    master_id_nxt    = master_id_r;
    master_valid_nxt = master_valid_r;
    valid_nxt        = valid_r;
    addr_nxt         = addr_r;
    chk_idx_nxt      = chk_idx_r;
    chk_nxt          = chk_r;
    free_found_nxt   = free_found_r;
    free_idx_nxt     = free_idx_r;
    res_status_nxt   = res_status_r;
    res_slot_nxt     = res_slot_r;
    ram_we           = 1'b0;
    ram_waddr        = free_sel;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        res_slot_nxt   = '0;
        addr_nxt       = '0;
        chk_nxt        = 1'b0;
        free_found_nxt = 1'b0;
        state_nxt      = S_FIN;
        unique case (cmd_r)
          cidat_pkg::CMD_PRESENT: begin
            if (!master_valid_r) begin
              master_id_nxt    = id_r;
              master_valid_nxt = 1'b1;
              res_status_nxt   = cidat_pkg::ST_ENROLLED;
            end else if (master_hit) begin
              res_status_nxt = cidat_pkg::ST_MASTER;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          cidat_pkg::CMD_ADD: begin
            if (master_hit) begin
              res_status_nxt = cidat_pkg::ST_MASTER;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          cidat_pkg::CMD_DELETE: begin
            // An empty table is reported before the master is looked at.
            if (tbl_empty) begin
              res_status_nxt = cidat_pkg::ST_EMPTY;
            end else if (master_hit) begin
              res_status_nxt = cidat_pkg::ST_MASTER;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          cidat_pkg::CMD_CLEAR: begin
            if (tbl_empty) begin
              res_status_nxt = cidat_pkg::ST_EMPTY;
            end else begin
              valid_nxt      = '0;
              res_status_nxt = cidat_pkg::ST_CLEARED;
            end
          end
        endcase
      end

      S_SCAN: begin
        chk_nxt     = 1'b1;
        chk_idx_nxt = addr_r;
        if (addr_r != LAST_IDX) begin
          addr_nxt = addr_r + IDX_W'(1);
        end
        if (chk_r && !valid_r[chk_idx_r] && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = chk_idx_r;
        end
        if (scan_end) begin
          state_nxt    = S_FIN;
          res_slot_nxt = '0;
          unique case (cmd_r)
            cidat_pkg::CMD_PRESENT: begin
              if (entry_hit) begin
                res_status_nxt = cidat_pkg::ST_GRANTED;
                res_slot_nxt   = cidat_pkg::SLOT_W'(chk_idx_r);
              end else begin
                res_status_nxt = cidat_pkg::ST_DENIED;
              end
            end
            cidat_pkg::CMD_ADD: begin
              if (entry_hit) begin
                res_status_nxt = cidat_pkg::ST_ALREADY;
                res_slot_nxt   = cidat_pkg::SLOT_W'(chk_idx_r);
              end else if (free_any) begin
                ram_we              = 1'b1;
                valid_nxt[free_sel] = 1'b1;
                res_status_nxt      = cidat_pkg::ST_ADDED;
                res_slot_nxt        = cidat_pkg::SLOT_W'(free_sel);
              end else begin
                res_status_nxt = cidat_pkg::ST_FULL;
              end
            end
            cidat_pkg::CMD_DELETE: begin
              if (entry_hit) begin
                valid_nxt[chk_idx_r] = 1'b0;
                res_status_nxt       = cidat_pkg::ST_DELETED;
                res_slot_nxt         = cidat_pkg::SLOT_W'(chk_idx_r);
              end else begin
                res_status_nxt = cidat_pkg::ST_NOTFOUND;
              end
            end
            cidat_pkg::CMD_CLEAR: begin
              // Clear is settled in the check state and never walks the table.
              res_status_nxt = cidat_pkg::ST_EMPTY;
            end
          endcase
        end
      end

      S_FIN: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      master_valid_r <= 1'b0;
      valid_r        <= '0;
      chk_r          <= 1'b0;
      free_found_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      master_valid_r <= master_valid_nxt;
      valid_r        <= valid_nxt;
      chk_r          <= chk_nxt;
      free_found_r   <= free_found_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_ch.cmd;
      id_r  <= in_ch.card_id;
    end
    master_id_r  <= master_id_nxt;
    addr_r       <= addr_nxt;
    chk_idx_r    <= chk_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    if (load_out) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
    end
  end

`ifndef SYNTHESIS
  // Once a master is enrolled it stays for good.
  a_master_kept: assert property (@(posedge clk) disable iff (!rst_n)
    master_valid_r |=> master_valid_r)
    else $error("master card lost after enrolment");

  // Enrolment stores the presented ID as master.
  a_enrol: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) && (cmd_r == cidat_pkg::CMD_PRESENT) && !master_valid_r
    |=> master_valid_r && (master_id_r == $past(id_r)))
    else $error("enrolment did not store the master ID");

  // A clear of a non-empty table leaves no valid slot.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) && (cmd_r == cidat_pkg::CMD_CLEAR) && !tbl_empty
    |=> (valid_r == '0))
    else $error("clear left a valid slot");

  // A slot is only reported with a status that names one.
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != cidat_pkg::ST_GRANTED)
    && (out_status_r != cidat_pkg::ST_ALREADY) && (out_status_r != cidat_pkg::ST_ADDED)
    && (out_status_r != cidat_pkg::ST_DELETED) |-> (out_slot_r == '0))
    else $error("slot reported with a status that has none");

  // An added slot is valid once the result is presented.
  a_added_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && (res_status_r == cidat_pkg::ST_ADDED)
    |-> valid_r[IDX_W'(res_slot_r)])
    else $error("added slot is not marked valid");
`endif

endmodule

[rtl/core/cidat_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
// It depends on nothing.
module cidat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Testbench for card_id_access_table_unit: directed cases, a full table, output back-pressure
// and a long random mix, with every result checked against a model of the table kept here.
// It depends on cidat_pkg, the channel interfaces in cidat_if and the top level itself.
module testbench;

  localparam int TABLE_ENTRIES = 32;
  // The slowest item walks the whole table, and neither side waits longer per item than
  // draw_wait allows, so the only long silence is the deliberate hold of the receiver.
  // The watchdog limit is set well above that hold.
  localparam int LONG_HOLD     = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_CHUNKS = 14;
  localparam int CHUNK_ITEMS   = 50;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    cidat_pkg::status_t status;
    cidat_pkg::slot_t   slot;
  } access_result_t;

  logic clk = 1'b0;
  logic rst_n;

  cidat_in_if  in_ch();
  cidat_out_if out_ch();

  card_id_access_table_unit #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // Our own copy of the table: the IDs, their valid marks and the master card.
  cidat_pkg::card_id_t stored_ids [TABLE_ENTRIES];
  bit                  slot_live  [TABLE_ENTRIES];
  cidat_pkg::card_id_t master_card;
  bit                  master_known;

  // Results still owed by the block, oldest first.
  access_result_t awaited_results[$];

  int unsigned fail_count;
  int unsigned idle_cycles;
  // When set, the side concerned runs without gaps.
  bit          in_calm;
  bit          out_calm;
  // Count of requests for the receiver to hold off with ready low; the receiver
  // keeps its own count of the holds it has served.
  int unsigned out_hold_request;

  // Applies one command to the table copy and returns the result that the block owes.
  // The search order follows the block: the master has precedence, emptiness means that
  // no valid mark is set, and the free slot is the lowest one whose mark is clear.
  function automatic access_result_t apply_card_command(cidat_pkg::cmd_t cmd,
                                                        cidat_pkg::card_id_t id);
    access_result_t res;
    int             hit;
    int             free_slot;
    int             k;
    bit             any_live;
    bit             is_master;
    res.status = cidat_pkg::ST_DENIED;
    res.slot   = '0;
    hit        = -1;
    free_slot  = -1;
    any_live   = 1'b0;
    for (k = 0; k < TABLE_ENTRIES; k++) begin
      if (slot_live[k]) begin
        any_live = 1'b1;
        if (hit < 0 && stored_ids[k] == id) hit = k;
      end else if (free_slot < 0) begin
        free_slot = k;
      end
    end
    is_master = master_known && master_card == id;
    case (cmd)
      cidat_pkg::CMD_PRESENT: begin
        if (!master_known) begin
          master_card  = id;
          master_known = 1'b1;
          res.status   = cidat_pkg::ST_ENROLLED;
        end else if (is_master) begin
          res.status = cidat_pkg::ST_MASTER;
        end else if (hit >= 0) begin
          res.status = cidat_pkg::ST_GRANTED;
          res.slot   = cidat_pkg::slot_t'(hit);
        end else begin
          res.status = cidat_pkg::ST_DENIED;
        end
      end
      cidat_pkg::CMD_ADD: begin
        if (is_master) begin
          res.status = cidat_pkg::ST_MASTER;
        end else if (hit >= 0) begin
          res.status = cidat_pkg::ST_ALREADY;
          res.slot   = cidat_pkg::slot_t'(hit);
        end else if (free_slot >= 0) begin
          stored_ids[free_slot] = id;
          slot_live[free_slot]  = 1'b1;
          res.status = cidat_pkg::ST_ADDED;
          res.slot   = cidat_pkg::slot_t'(free_slot);
        end else begin
          res.status = cidat_pkg::ST_FULL;
        end
      end
      cidat_pkg::CMD_DELETE: begin
        // An empty table is reported before the master is looked at.
        if (!any_live) begin
          res.status = cidat_pkg::ST_EMPTY;
        end else if (is_master) begin
          res.status = cidat_pkg::ST_MASTER;
        end else if (hit >= 0) begin
          slot_live[hit] = 1'b0;
          res.status = cidat_pkg::ST_DELETED;
          res.slot   = cidat_pkg::slot_t'(hit);
        end else begin
          res.status = cidat_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        if (!any_live) begin
          res.status = cidat_pkg::ST_EMPTY;
        end else begin
          for (k = 0; k < TABLE_ENTRIES; k++) slot_live[k] = 1'b0;
          res.status = cidat_pkg::ST_CLEARED;
        end
      end
    endcase
    return res;
  endfunction

  // Gap before an item or a result: none when calm, else often none and otherwise random.
  function automatic int unsigned draw_wait(bit calm);
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // Mostly IDs that mean something to the table (live entries, the master, a handful of
  // small values that recur), the rest fresh random IDs that exercise every bit.
  function automatic cidat_pkg::card_id_t pick_card_id();
    int unsigned roll;
    int unsigned live_count;
    int unsigned target;
    int          k;
    roll       = $urandom_range(0, 9);
    live_count = 0;
    if (roll <= 3) return cidat_pkg::card_id_t'($urandom());
    for (k = 0; k < TABLE_ENTRIES; k++) if (slot_live[k]) live_count++;
    if (roll <= 7 && live_count != 0) begin
      target = $urandom_range(0, live_count - 1);
      for (k = 0; k < TABLE_ENTRIES; k++) begin
        if (slot_live[k]) begin
          if (target == 0) return stored_ids[k];
          target--;
        end
      end
    end
    if (roll == 8 && master_known) return master_card;
    return cidat_pkg::card_id_t'($urandom_range(0, 3));
  endfunction

  function automatic void note_failure(string what);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("mismatch: %s", what);
  endfunction

  // Offers one item after a random gap and waits for it to be taken. The valid line is
  // left high, so that an item that follows without a gap goes straight on.
  task automatic send_card(cidat_pkg::cmd_t cmd, cidat_pkg::card_id_t id);
    int unsigned gap;
    gap = draw_wait(in_calm);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= cmd;
    in_ch.card_id <= id;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    awaited_results.push_back(apply_card_command(cmd, id));
  endtask

  // Stops offering items until the block has handed back every result that it owes.
  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Delete, clear and add without a master, enrolment, and every outcome of present, add,
  // delete and clear but a full table, which the next test covers.
  task automatic test_directed_cases();
    send_card(cidat_pkg::CMD_DELETE,  32'h0000_0000);  // Empty table and no master yet.
    send_card(cidat_pkg::CMD_CLEAR,   32'hFFFF_FFFF);  // Clear of an empty table.
    send_card(cidat_pkg::CMD_ADD,     32'hFFFF_FFFF);  // Add works before any master exists.
    send_card(cidat_pkg::CMD_DELETE,  32'h0000_1234);  // Not found, no master to match.
    send_card(cidat_pkg::CMD_PRESENT, 32'h0000_0000);  // Enrols the all-zero ID as master.
    send_card(cidat_pkg::CMD_PRESENT, 32'h0000_0000);
    send_card(cidat_pkg::CMD_PRESENT, 32'hFFFF_FFFF);
    send_card(cidat_pkg::CMD_PRESENT, 32'hA5A5_A5A5);
    send_card(cidat_pkg::CMD_ADD,     32'h0000_0000);  // Add of the master changes nothing.
    send_card(cidat_pkg::CMD_ADD,     32'hFFFF_FFFF);
    send_card(cidat_pkg::CMD_ADD,     32'h5A5A_5A5A);
    send_card(cidat_pkg::CMD_DELETE,  32'h0000_0000);  // Delete of the master, table in use.
    send_card(cidat_pkg::CMD_DELETE,  32'hFFFF_FFFF);
    send_card(cidat_pkg::CMD_ADD,     32'h0000_0001);  // Reuses the slot that was just freed.
    send_card(cidat_pkg::CMD_PRESENT, 32'h5A5A_5A5A);
    send_card(cidat_pkg::CMD_CLEAR,   32'h1234_5678);
    send_card(cidat_pkg::CMD_DELETE,  32'h0000_0000);  // The master gets empty once the table is.
    send_card(cidat_pkg::CMD_CLEAR,   32'h0000_0000);
    send_card(cidat_pkg::CMD_PRESENT, 32'h8000_0000);
    send_card(cidat_pkg::CMD_PRESENT, 32'h0000_0000);  // Clear keeps the master.
    pause_until_drained();
  endtask

  // Fills every slot with distinct random IDs, then overflows, frees a slot in the
  // middle and refills it. The table is left full for the random mix to start from.
  task automatic test_table_full();
    cidat_pkg::card_id_t fill_ids [TABLE_ENTRIES];
    int                  k;
    // The top byte keeps the IDs distinct and away from the all-zero master.
    for (k = 0; k < TABLE_ENTRIES; k++) fill_ids[k] = {8'(k + 1), 24'($urandom())};
    for (k = 0; k < TABLE_ENTRIES; k++) send_card(cidat_pkg::CMD_ADD, fill_ids[k]);
    send_card(cidat_pkg::CMD_ADD,     ~fill_ids[0]);
    send_card(cidat_pkg::CMD_ADD,     fill_ids[5]);
    send_card(cidat_pkg::CMD_ADD,     master_card);
    send_card(cidat_pkg::CMD_PRESENT, fill_ids[TABLE_ENTRIES - 1]);
    send_card(cidat_pkg::CMD_DELETE,  fill_ids[17]);
    send_card(cidat_pkg::CMD_ADD,     ~fill_ids[0]);
    send_card(cidat_pkg::CMD_PRESENT, fill_ids[17]);
    send_card(cidat_pkg::CMD_ADD,     ~fill_ids[1]);
    pause_until_drained();
  endtask

  // The receiver holds off for a long stretch while items keep coming without gaps, so
  // that the result register fills and the block has to stall its input.
  task automatic test_output_stall();
    int k;
    out_hold_request++;
    in_calm = 1'b1;
    for (k = 0; k < 12; k++) begin
      send_card((k % 2 != 0) ? cidat_pkg::CMD_PRESENT : cidat_pkg::CMD_ADD, pick_card_id());
    end
    in_calm = 1'b0;
    pause_until_drained();
  endtask

  // Random commands in chunks. Every third chunk leans on add so that the table fills up,
  // the others give delete a larger share; clear is rare. Every fourth chunk ends
  // with the sender waiting for all results.
  task automatic test_random_mix();
    int              chunk;
    int              k;
    int unsigned     roll;
    int unsigned     add_share;
    cidat_pkg::cmd_t cmd;
    for (chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      in_calm   = ($urandom_range(0, 4) == 0);
      out_calm  = ($urandom_range(0, 4) == 0);
      add_share = (chunk % 3 == 0) ? 60 : 40;
      for (k = 0; k < CHUNK_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < add_share) cmd = cidat_pkg::CMD_ADD;
        else if (roll < add_share + 30) cmd = cidat_pkg::CMD_PRESENT;
        else if (roll < 98) cmd = cidat_pkg::CMD_DELETE;
        else cmd = cidat_pkg::CMD_CLEAR;
        send_card(cmd, pick_card_id());
      end
      if (chunk % 4 == 3) pause_until_drained();
    end
    in_calm  = 1'b0;
    out_calm = 1'b0;
  endtask

  // Result side: ready is dropped for a random number of cycles before each result, or
  // for the long stretch when one has been asked for.
  initial begin : result_sink
    int unsigned stall;
    int unsigned holds_served;
    holds_served = 0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (out_hold_request != holds_served) begin
        stall = LONG_HOLD;
        holds_served++;
      end else begin
        stall = draw_wait(out_calm);
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  // Every result taken is compared field by field with the oldest one owed.
  always @(posedge clk) begin : result_check
    access_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        note_failure($sformatf("result with none expected: status %0d slot %0d",
                               out_ch.status, out_ch.slot));
      end else begin
        want = awaited_results.pop_front();
        if (want.status !== out_ch.status)
          note_failure($sformatf("status expected %0d actual %0d", want.status, out_ch.status));
        if (want.slot !== out_ch.slot)
          note_failure($sformatf("slot expected %0d actual %0d (status %0d)",
                                 want.slot, out_ch.slot, want.status));
      end
    end
  end

  // The run is abandoned when neither channel moves an item for too long.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.cmd     <= cidat_pkg::CMD_PRESENT;
    in_ch.card_id <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_table_full();
    test_output_stall();
    test_random_mix();

    // Everything has been offered: wait for the last results, then a little longer in
    // case the block produces anything it should not.
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/cidat_pkg.sv
rtl/core/cidat_if.sv
rtl/core/cidat_ram.sv
rtl/core/card_id_access_table_unit.sv
dv/testbench.sv
